>>> src/bbmd_pkg.sv
`timescale 1ns / 1ps

package bbmd_pkg;

  localparam int unsigned LOG_W   = 38;  // 6 integer bits, 32 fraction bits
  localparam int unsigned L_W     = 42;  // signed log2 sum
  localparam int unsigned Q_W     = 50;  // quotient bits per division
  localparam int unsigned DIV_PRE = 18;  // low dividend bits shifted in by the first steps

  localparam int unsigned LOG_LAT   = 66;
  localparam int unsigned DIV_LAT   = Q_W;
  localparam int unsigned ALIGN_LAT = LOG_LAT - DIV_LAT;
  localparam int unsigned BACK_LAT  = 9;

  localparam logic [31:0] MU_MASS  = 32'd443162;        // Q.22
  localparam logic [21:0] E_MASS   = 22'd2194728;       // Q.32
  localparam logic [31:0] LN2      = 32'd2977044472;    // Q.32
  localparam logic [39:0] LOSS_MAX = 40'hFF_FFFF_FFFF;

  localparam logic [63:0] MI2     = 64'(MU_MASS) * 64'(MU_MASS);
  localparam logic [63:0] D_CONST = (MI2 << 10) + ((64'(E_MASS) * 64'(E_MASS)) >> 10);

  localparam logic [63:0] EXC_AIR  = 64'd24122406;      // Q.48
  localparam logic [63:0] EXC_ROCK = 64'd38393187;
  localparam logic [35:0] KZA_AIR  = 36'd43136414543;   // Q.48
  localparam logic [35:0] KZA_ROCK = 36'd43206408925;

  typedef struct packed {
    logic valid;
    logic sel;   // material
    logic zero;  // force zero result, flag invalid
  } side_t;

  // log2 in Q32 by repeated squaring; elaboration only
  function automatic logic [LOG_W-1:0] log2_const(input logic [63:0] x);
    logic [62:0]  m;
    logic [63:0]  mm;
    logic [127:0] sq;
    logic [31:0]  frac;
    int           n;
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = i;
    end
    if (n <= 62) m = 63'(x << (62 - n));
    else m = x[63:1];
    frac = '0;
    for (int i = 0; i < 32; i++) begin
      sq   = {65'd0, m} * {65'd0, m};
      mm   = sq[125:62];
      frac = {frac[30:0], mm[63]};
      if (mm[63]) m = mm[63:1];
      else m = mm[62:0];
    end
    return {6'(n), frac};
  endfunction

  localparam longint LC_AIR = 2 * longint'(log2_const(64'(E_MASS)))
      - longint'(log2_const(MI2)) - 2 * longint'(log2_const(EXC_AIR))
      + (longint'(44) <<< 32);
  localparam longint LC_ROCK = 2 * longint'(log2_const(64'(E_MASS)))
      - longint'(log2_const(MI2)) - 2 * longint'(log2_const(EXC_ROCK))
      + (longint'(44) <<< 32);

  localparam logic signed [L_W-1:0] LCONST_AIR  = L_W'(LC_AIR);
  localparam logic signed [L_W-1:0] LCONST_ROCK = L_W'(LC_ROCK);

endpackage

>>> src/bbmd_front.sv
`timescale 1ns / 1ps

module bbmd_front import bbmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic        sel_i,
  input  logic [31:0] energy_i,
  output side_t       side_o,
  output logic [63:0] p2_o,
  output logic [63:0] d54_o,
  output logic [63:0] e2_o
);

  side_t       side1_q, side2_q;
  logic [63:0] e2_1_q, e2_2_q, p2_q, d54_q;
  logic [53:0] mee_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
    end else if (en_i) begin
      side1_q <= '{valid: valid_i, sel: sel_i, zero: (energy_i <= MU_MASS)};
      side2_q <= side1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e2_1_q <= 64'(energy_i) * 64'(energy_i);
      mee_q  <= 54'(E_MASS) * 54'(energy_i);
      e2_2_q <= e2_1_q;
      p2_q   <= e2_1_q - MI2;
      d54_q  <= D_CONST + {9'd0, mee_q, 1'b0};
    end
  end

  assign side_o = side2_q;
  assign p2_o   = p2_q;
  assign d54_o  = d54_q;
  assign e2_o   = e2_2_q;

endmodule

>>> src/bbmd_log2.sv
`timescale 1ns / 1ps

module bbmd_log2 import bbmd_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [63:0]      x_i,
  output logic [LOG_W-1:0] y_o
);

  logic [5:0]  msb;
  logic [63:0] x0_q;
  logic [6:0]  tag0_q, tag1_q;   // {zero, msb index}
  logic [62:0] m1_q;

  logic [62:0] m_b_q    [32];
  logic [31:0] frac_a_q [32];
  logic [31:0] frac_b_q [32];
  logic [6:0]  tag_a_q  [32];
  logic [6:0]  tag_b_q  [32];
  logic [63:0] p00_q    [32];
  logic [62:0] p01_q    [32];
  logic [61:0] p11_q    [32];

  always_comb begin
    msb = '0;
    for (int i = 0; i < 64; i++) begin
      if (x_i[i]) msb = 6'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q   <= x_i;
      tag0_q <= {(x_i == '0), msb};
      tag1_q <= tag0_q;
      if (tag0_q[5:0] == 6'd63) m1_q <= x0_q[63:1];
      else m1_q <= 63'(x0_q << (6'd62 - tag0_q[5:0]));
    end
  end

  for (genvar i = 0; i < 32; i++) begin : g_iter
    logic [62:0]  m_src;
    logic [31:0]  f_src;
    logic [6:0]   t_src;
    logic [125:0] sq;
    logic [63:0]  mm;

    if (i == 0) begin : g_first
      assign m_src = m1_q;
      assign f_src = '0;
      assign t_src = tag1_q;
    end else begin : g_next
      assign m_src = m_b_q[i-1];
      assign f_src = frac_b_q[i-1];
      assign t_src = tag_b_q[i-1];
    end

    assign sq = {p11_q[i], 64'd0} + {30'd0, p01_q[i], 33'd0} + {62'd0, p00_q[i]};
    assign mm = sq[125:62];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // square in partial products, then normalize next cycle
        p00_q[i]    <= 64'(m_src[31:0]) * 64'(m_src[31:0]);
        p01_q[i]    <= 63'(m_src[31:0]) * 63'(m_src[62:32]);
        p11_q[i]    <= 62'(m_src[62:32]) * 62'(m_src[62:32]);
        frac_a_q[i] <= f_src;
        tag_a_q[i]  <= t_src;
        m_b_q[i]    <= mm[63] ? mm[63:1] : mm[62:0];
        frac_b_q[i] <= {frac_a_q[i][30:0], mm[63]};
        tag_b_q[i]  <= tag_a_q[i];
      end
    end
  end

  assign y_o = tag_b_q[31][6] ? '0 : {tag_b_q[31][5:0], frac_b_q[31]};

endmodule

>>> src/bbmd_div.sv
`timescale 1ns / 1ps

module bbmd_div import bbmd_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [63:0]    num_i,
  input  logic [63:0]    den_i,
  output logic [Q_W-1:0] q_o
);

  // floor(num * 2^32 / den), one restoring step per stage
  logic [63:0]    r_q [Q_W];
  logic [Q_W-1:0] w_q [Q_W];   // remaining dividend bits, then quotient bits
  logic [63:0]    d_q [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [63:0]    r_src, d_src;
    logic [Q_W-1:0] w_src;
    logic [64:0]    t, diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign r_src = {{DIV_PRE{1'b0}}, num_i[63:DIV_PRE]};
      assign w_src = {num_i[DIV_PRE-1:0], 32'd0};
      assign d_src = den_i;
    end else begin : g_next
      assign r_src = r_q[i-1];
      assign w_src = w_q[i-1];
      assign d_src = d_q[i-1];
    end

    assign t    = {r_src, w_src[Q_W-1]};
    assign diff = t - {1'b0, d_src};
    assign ge   = (t >= {1'b0, d_src});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i] <= ge ? diff[63:0] : t[63:0];
        w_q[i] <= {w_src[Q_W-2:0], ge};
        d_q[i] <= d_src;
      end
    end
  end

  assign q_o = w_q[Q_W-1];

endmodule

>>> src/bbmd_back.sv
`timescale 1ns / 1ps

module bbmd_back import bbmd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  side_t            side_i,
  input  logic [LOG_W-1:0] lp2_i,
  input  logic [LOG_W-1:0] ld54_i,
  input  logic [31:0]      beta2_i,
  input  logic [Q_W-1:0]   inv_i,
  output logic             valid_o,
  output logic [39:0]      loss_o,
  output logic             invalid_o
);

  side_t side_q [BACK_LAT];
  side_t side5_d;

  logic [31:0]           beta2_q [4];
  logic [Q_W-1:0]        inv_q   [5];
  logic signed [L_W-1:0] l1_q;
  logic                  neg2_q, neg3_q, neg4_q;
  logic [40:0]           mag2_q;
  logic [63:0]           pl3_q;
  logic [40:0]           ph3_q;
  logic [39:0]           h4_q;
  logic [39:0]           brk5_q;
  logic [63:0]           ll6_q;
  logic [39:0]           lh6_q;
  logic [49:0]           hl6_q;
  logic [25:0]           hh6_q;
  logic [57:0]           t7_q;
  logic [67:0]           tl8_q;
  logic [61:0]           th8_q;
  logic [39:0]           loss_q;
  logic                  inv_flag_q;

  logic signed [L_W-1:0] l_sum, hs, brk;
  logic [72:0]           h_prod;
  logic [89:0]           t_prod;
  logic [93:0]           loss_prod;
  logic [49:0]           loss_full;
  logic [35:0]           kza;

  assign l_sum = $signed({3'd0, lp2_i, 1'b0}) - $signed({4'd0, ld54_i})
               + (side_i.sel ? LCONST_ROCK : LCONST_AIR);

  assign h_prod = {ph3_q, 32'd0} + {9'd0, pl3_q};
  assign hs     = neg4_q ? -$signed({2'd0, h4_q}) : $signed({2'd0, h4_q});
  assign brk    = hs - $signed({10'd0, beta2_q[3]});

  // a negative bracket forces a zero result
  always_comb begin
    side5_d      = side_q[3];
    side5_d.zero = side_q[3].zero | brk[L_W-1];
  end

  assign t_prod = {hh6_q, 64'd0} + {18'd0, lh6_q, 32'd0} + {8'd0, hl6_q, 32'd0}
                + {26'd0, ll6_q};
  assign kza    = side_q[6].sel ? KZA_ROCK : KZA_AIR;

  assign loss_prod = {th8_q, 32'd0} + {26'd0, tl8_q};
  assign loss_full = loss_prod[93:44];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BACK_LAT; k++) side_q[k] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
      side_q[3] <= side_q[2];
      side_q[4] <= side5_d;
      side_q[5] <= side_q[4];
      side_q[6] <= side_q[5];
      side_q[7] <= side_q[6];
      side_q[8] <= side_q[7];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beta2_q[0] <= beta2_i;
      for (int k = 1; k < 4; k++) beta2_q[k] <= beta2_q[k-1];
      inv_q[0] <= inv_i;
      for (int k = 1; k < 5; k++) inv_q[k] <= inv_q[k-1];

      l1_q   <= l_sum;
      neg2_q <= l1_q[L_W-1];
      mag2_q <= l1_q[L_W-1] ? 41'(-l1_q) : l1_q[40:0];
      neg3_q <= neg2_q;
      pl3_q  <= 64'(mag2_q[31:0]) * 64'(LN2);
      ph3_q  <= 41'(mag2_q[40:32]) * 41'(LN2);
      neg4_q <= neg3_q;
      h4_q   <= h_prod[72:33];
      brk5_q <= brk[39:0];

      ll6_q <= 64'(inv_q[4][31:0]) * 64'(brk5_q[31:0]);
      lh6_q <= 40'(inv_q[4][31:0]) * 40'(brk5_q[39:32]);
      hl6_q <= 50'(inv_q[4][49:32]) * 50'(brk5_q[31:0]);
      hh6_q <= 26'(inv_q[4][49:32]) * 26'(brk5_q[39:32]);
      t7_q  <= t_prod[89:32];
      tl8_q <= 68'(t7_q[31:0]) * 68'(kza);
      th8_q <= 62'(t7_q[57:32]) * 62'(kza);

      if (side_q[7].zero) begin
        loss_q     <= '0;
        inv_flag_q <= 1'b1;
      end else if (loss_full[49:40] != '0) begin
        loss_q     <= LOSS_MAX;
        inv_flag_q <= 1'b1;
      end else begin
        loss_q     <= loss_full[39:0];
        inv_flag_q <= 1'b0;
      end
    end
  end

  assign valid_o   = side_q[8].valid;
  assign loss_o    = loss_q;
  assign invalid_o = inv_flag_q;

endmodule

>>> src/bethe_bloch_muon_dedx.sv
`timescale 1ns / 1ps

// Muon mean energy loss (stopping power) per unit mass thickness.
// Input channel: energy_i (total energy, Q10.22 GeV) with in_valid_i and
// in_stall_o. Output channel: loss_rate_o (GeV per g/cm2, units 2^-36) and
// invalid_o with out_valid_o and out_stall_i. An item moves on a clock edge
// where valid is high and stall is low.
// cfg_we_i writes cfg_wdata_i into the material register (0 air, 1 rock);
// write it only while no item is in flight.
// Pipeline: 2 front stages (square, momentum), 66 stages of the log2 units
// (msb search, normalize, then 32 squaring steps, each a partial-product
// and a normalize stage), and 9 back stages (log sum, scale, bracket, two
// split multiplies, clamp). The two restoring dividers (beta^2, 1/beta^2)
// run beside the log units. Throughput is one item per cycle unless stalled.
// While the output holds an item and out_stall_i is high, the whole pipeline
// freezes and in_stall_o is high; nothing is dropped or repeated.
// Reset clears all valid bits and sets the material to air.
// Energies at or below the muon mass, negative brackets and overflowing
// results come out flagged invalid with a loss of zero or full scale.

module bethe_bloch_muon_dedx import bbmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] energy_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [39:0] loss_rate_o,
  output logic        invalid_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  logic material_q;
  logic en;

  side_t            front_side;
  logic [63:0]      p2, d54, e2;
  logic [LOG_W-1:0] lp2, ld54;
  logic [Q_W-1:0]   beta2_q_full, inv_full;

  side_t            side_dly_q  [LOG_LAT];
  logic [31:0]      beta2_dly_q [ALIGN_LAT];
  logic [Q_W-1:0]   inv_dly_q   [ALIGN_LAT];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      material_q <= 1'b0;
    end else if (cfg_we_i) begin
      material_q <= cfg_wdata_i;
    end
  end

  bbmd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .sel_i    (material_q),
    .energy_i (energy_i),
    .side_o   (front_side),
    .p2_o     (p2),
    .d54_o    (d54),
    .e2_o     (e2)
  );

  bbmd_log2 u_log_p2 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (p2),
    .y_o   (lp2)
  );

  bbmd_log2 u_log_d54 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (d54),
    .y_o   (ld54)
  );

  bbmd_div u_div_beta2 (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (p2),
    .den_i (e2),
    .q_o   (beta2_q_full)
  );

  bbmd_div u_div_inv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (e2),
    .den_i (p2),
    .q_o   (inv_full)
  );

  // align side band with the log units and quotients with the logs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LOG_LAT; k++) side_dly_q[k] <= '0;
    end else if (en) begin
      side_dly_q[0] <= front_side;
      for (int k = 1; k < LOG_LAT; k++) side_dly_q[k] <= side_dly_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      beta2_dly_q[0] <= beta2_q_full[31:0];
      inv_dly_q[0]   <= inv_full;
      for (int k = 1; k < ALIGN_LAT; k++) begin
        beta2_dly_q[k] <= beta2_dly_q[k-1];
        inv_dly_q[k]   <= inv_dly_q[k-1];
      end
    end
  end

  bbmd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .side_i    (side_dly_q[LOG_LAT-1]),
    .lp2_i     (lp2),
    .ld54_i    (ld54),
    .beta2_i   (beta2_dly_q[ALIGN_LAT-1]),
    .inv_i     (inv_dly_q[ALIGN_LAT-1]),
    .valid_o   (out_valid_o),
    .loss_o    (loss_rate_o),
    .invalid_o (invalid_o)
  );

  a_flag_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> loss_rate_o == '0 || loss_rate_o == LOSS_MAX)
    else $error("invalid result not clamped");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(side_dly_q[LOG_LAT-1]))
    else $error("pipeline moved during stall");

endmodule
